// ===== hw/rtl/spam_pkg.sv =====
// Shared types and constants for the sparse polynomial add/multiply block.
`default_nettype none

package spam_pkg;

   // Default list capacity (terms per polynomial)
   localparam int MAX_TERMS_DEF = 8;

   // Item kinds on the request channel
   typedef enum logic [2:0] {
      KIND_CLEAR    = 3'd0,
      KIND_APPEND_A = 3'd1,
      KIND_APPEND_B = 3'd2,
      KIND_SUM      = 3'd3,
      KIND_PRODUCT  = 3'd4
   } kind_type;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SUM,
      ST_PRODUCT
   } state_type;

   // One stored term
   typedef struct packed {
      logic signed [15:0] coeff;
      logic [7:0]         exponent;
   } term_type;

endpackage : spam_pkg

`default_nettype wire

// ===== hw/rtl/spam_term_mem.sv =====
// Term list memory: one write port, one read port with registered read data.
`default_nettype none

module spam_term_mem #(
   parameter int MAX_TERMS = spam_pkg::MAX_TERMS_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  wr_en,
   input  wire logic [(MAX_TERMS > 1 ? $clog2(MAX_TERMS) : 1)-1:0] wr_addr,
   input  wire spam_pkg::term_type                    wr_term,
   input  wire logic [(MAX_TERMS > 1 ? $clog2(MAX_TERMS) : 1)-1:0] rd_addr,
   output      spam_pkg::term_type                    rd_term
);

   localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
   localparam int DEPTH = 1 << IDX_W;

   spam_pkg::term_type mem_ff [DEPTH];
   spam_pkg::term_type rd_term_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_term;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      rd_term_ff <= mem_ff[rd_addr];
   end

   assign rd_term = rd_term_ff;

endmodule : spam_term_mem

`default_nettype wire

// ===== hw/rtl/spam_engine.sv =====
// Sequencer: list counts, merge/product walk over the term memories, result register.
`default_nettype none

module spam_engine #(
   parameter int MAX_TERMS = spam_pkg::MAX_TERMS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   // request channel
   input  wire logic                start,
   output      logic                busy,
   input  wire logic [2:0]          req_kind,
   input  wire logic signed [15:0]  req_term_coeff,
   input  wire logic [7:0]          req_term_exponent,
   // memory ports
   output      logic                wr_a,
   output      logic                wr_b,
   output      logic [(MAX_TERMS > 1 ? $clog2(MAX_TERMS) : 1)-1:0] wr_addr,
   output      spam_pkg::term_type  wr_term,
   output      logic [(MAX_TERMS > 1 ? $clog2(MAX_TERMS) : 1)-1:0] rd_addr_a,
   output      logic [(MAX_TERMS > 1 ? $clog2(MAX_TERMS) : 1)-1:0] rd_addr_b,
   input  wire spam_pkg::term_type  rd_term_a,
   input  wire spam_pkg::term_type  rd_term_b,
   // result channel
   output      logic                rsp_valid,
   output      logic signed [31:0]  rsp_result_coeff,
   output      logic [8:0]          rsp_result_exponent,
   output      logic                rsp_term_valid,
   output      logic                rsp_last_term,
   output      logic                rsp_overflow_seen
);

   localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
   localparam int CNT_W = $clog2(MAX_TERMS + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TERMS);
   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

   spam_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0] count_a_ff, count_a_in;
   logic [CNT_W-1:0] count_b_ff, count_b_in;
   logic [CNT_W-1:0] i_ff, i_in;
   logic [CNT_W-1:0] j_ff, j_in;
   logic             ovf_ff, ovf_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_coeff_ff, rsp_coeff_in;
   logic [8:0]       rsp_expo_ff, rsp_expo_in;
   logic             rsp_tvalid_ff, rsp_tvalid_in;
   logic             rsp_last_ff, rsp_last_in;
   logic             rsp_ovf_ff, rsp_ovf_in;

   // datapath terms from the memory read registers
   logic signed [15:0] a_c, b_c;
   logic [7:0]         a_e, b_e;
   logic signed [16:0] sum_c;
   logic signed [31:0] prod_c;
   logic [8:0]         prod_e;
   logic [CNT_W-1:0]   i_inc, j_inc;
   logic               a_more, b_more;

   assign a_c    = rd_term_a.coeff;
   assign b_c    = rd_term_b.coeff;
   assign a_e    = rd_term_a.exponent;
   assign b_e    = rd_term_b.exponent;
   assign sum_c  = 17'(a_c) + 17'(b_c);
   assign prod_c = a_c * b_c;
   assign prod_e = 9'(a_e) + 9'(b_e);
   assign i_inc  = i_ff + CNT_ONE;
   assign j_inc  = j_ff + CNT_ONE;
   assign a_more = i_ff < count_a_ff;
   assign b_more = j_ff < count_b_ff;

   // state and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spam_pkg::ST_IDLE;
         count_a_ff   <= '0;
         count_b_ff   <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_a_ff   <= count_a_in;
         count_b_ff   <= count_b_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_coeff_ff  <= rsp_coeff_in;
      rsp_expo_ff   <= rsp_expo_in;
      rsp_tvalid_ff <= rsp_tvalid_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_ovf_ff    <= rsp_ovf_in;
   end

   // next state, memory control and result
   always_comb begin
      state_in      = state_ff;
      count_a_in    = count_a_ff;
      count_b_in    = count_b_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      ovf_in        = ovf_ff;
      rsp_valid_in  = 1'b0;
      rsp_coeff_in  = rsp_coeff_ff;
      rsp_expo_in   = rsp_expo_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_ovf_in    = ovf_ff;
      wr_a          = 1'b0;
      wr_b          = 1'b0;
      wr_addr       = count_a_ff[IDX_W-1:0];
      wr_term.coeff    = req_term_coeff;
      wr_term.exponent = req_term_exponent;

      unique case (state_ff)
         spam_pkg::ST_IDLE: begin
            // walks always start from the list heads
            i_in = '0;
            j_in = '0;
            if (start) begin
               unique case (req_kind)
                  spam_pkg::KIND_CLEAR: begin
                     count_a_in = '0;
                     count_b_in = '0;
                     ovf_in     = 1'b0;
                  end
                  spam_pkg::KIND_APPEND_A: begin
                     if (count_a_ff < CNT_MAX) begin
                        wr_a       = 1'b1;
                        count_a_in = count_a_ff + CNT_ONE;
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  spam_pkg::KIND_APPEND_B: begin
                     wr_addr = count_b_ff[IDX_W-1:0];
                     if (count_b_ff < CNT_MAX) begin
                        wr_b       = 1'b1;
                        count_b_in = count_b_ff + CNT_ONE;
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  spam_pkg::KIND_SUM:     state_in = spam_pkg::ST_SUM;
                  spam_pkg::KIND_PRODUCT: state_in = spam_pkg::ST_PRODUCT;
                  default: ;
               endcase
            end
         end

         spam_pkg::ST_SUM: begin
            rsp_valid_in  = 1'b1;
            rsp_tvalid_in = 1'b1;
            if (!a_more && !b_more) begin
               // both lists empty
               rsp_coeff_in  = '0;
               rsp_expo_in   = '0;
               rsp_tvalid_in = 1'b0;
            end else if (!a_more) begin
               rsp_coeff_in = 32'(b_c);
               rsp_expo_in  = 9'(b_e);
               j_in         = j_inc;
            end else if (!b_more) begin
               rsp_coeff_in = 32'(a_c);
               rsp_expo_in  = 9'(a_e);
               i_in         = i_inc;
            end else if (a_e == b_e) begin
               rsp_coeff_in = 32'(sum_c);
               rsp_expo_in  = 9'(a_e);
               i_in         = i_inc;
               j_in         = j_inc;
            end else if (a_e > b_e) begin
               rsp_coeff_in = 32'(a_c);
               rsp_expo_in  = 9'(a_e);
               i_in         = i_inc;
            end else begin
               rsp_coeff_in = 32'(b_c);
               rsp_expo_in  = 9'(b_e);
               j_in         = j_inc;
            end
            rsp_last_in = (i_in >= count_a_ff) && (j_in >= count_b_ff);
            if (rsp_last_in) begin
               state_in = spam_pkg::ST_IDLE;
            end
         end

         spam_pkg::ST_PRODUCT: begin
            rsp_valid_in = 1'b1;
            if (count_a_ff == '0 || count_b_ff == '0) begin
               // nothing to multiply
               rsp_coeff_in  = '0;
               rsp_expo_in   = '0;
               rsp_tvalid_in = 1'b0;
               rsp_last_in   = 1'b1;
               state_in      = spam_pkg::ST_IDLE;
            end else begin
               rsp_coeff_in  = prod_c;
               rsp_expo_in   = prod_e;
               rsp_tvalid_in = 1'b1;
               rsp_last_in   = (i_inc == count_a_ff) && (j_inc == count_b_ff);
               // B runs fastest
               if (j_inc == count_b_ff) begin
                  j_in = '0;
                  i_in = i_inc;
               end else begin
                  j_in = j_inc;
               end
               if (rsp_last_in) begin
                  state_in = spam_pkg::ST_IDLE;
               end
            end
         end

         default: state_in = spam_pkg::ST_IDLE;
      endcase
   end

   // reads follow the next walk position so data lines up with i_ff/j_ff
   assign rd_addr_a = i_in[IDX_W-1:0];
   assign rd_addr_b = j_in[IDX_W-1:0];

   assign busy                = state_ff != spam_pkg::ST_IDLE;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_result_coeff    = rsp_coeff_ff;
   assign rsp_result_exponent = rsp_expo_ff;
   assign rsp_term_valid      = rsp_tvalid_ff;
   assign rsp_last_term       = rsp_last_ff;
   assign rsp_overflow_seen   = rsp_ovf_ff;

endmodule : spam_engine

`default_nettype wire

// ===== hw/rtl/sparse_polynomial_add_multiply.sv =====
// Sparse polynomial add/multiply: top level with the two term memories and the sequencer.
//
// Clear and append items are taken while idle and keep busy low. A sum
// or product item holds busy while its results are produced: count_a + count_b
// results at most for a sum (fewer where exponents match), count_a * count_b
// for a product, and one result for an empty answer. Results stream one per
// cycle; the first reaches the rsp_ ports through the term memory read
// register and then the result register, and the last result shows in the
// first cycle with busy low, so the next item can be taken at the edge that
// ends that cycle.
// The receiver cannot stall: each result is on the rsp_ ports for one cycle,
// marked by rsp_valid, and the last one carries rsp_last_term.
`default_nettype none

module sparse_polynomial_add_multiply #(
   parameter int MAX_TERMS = spam_pkg::MAX_TERMS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output      logic               busy,
   input  wire logic [2:0]         req_kind,
   input  wire logic signed [15:0] req_term_coeff,
   input  wire logic [7:0]         req_term_exponent,
   output      logic               rsp_valid,
   output      logic signed [31:0] rsp_result_coeff,
   output      logic [8:0]         rsp_result_exponent,
   output      logic               rsp_term_valid,
   output      logic               rsp_last_term,
   output      logic               rsp_overflow_seen
);

   localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

   logic               wr_a, wr_b;
   logic [IDX_W-1:0]   wr_addr;
   spam_pkg::term_type wr_term;
   logic [IDX_W-1:0]   rd_addr_a, rd_addr_b;
   spam_pkg::term_type rd_term_a, rd_term_b;

   // list A storage
   spam_term_mem #(.MAX_TERMS(MAX_TERMS)) u_mem_a (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (wr_addr),
      .wr_term (wr_term),
      .rd_addr (rd_addr_a),
      .rd_term (rd_term_a)
   );

   // list B storage
   spam_term_mem #(.MAX_TERMS(MAX_TERMS)) u_mem_b (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (wr_addr),
      .wr_term (wr_term),
      .rd_addr (rd_addr_b),
      .rd_term (rd_term_b)
   );

   // sequencer and result register
   spam_engine #(.MAX_TERMS(MAX_TERMS)) u_engine (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_kind            (req_kind),
      .req_term_coeff      (req_term_coeff),
      .req_term_exponent   (req_term_exponent),
      .wr_a                (wr_a),
      .wr_b                (wr_b),
      .wr_addr             (wr_addr),
      .wr_term             (wr_term),
      .rd_addr_a           (rd_addr_a),
      .rd_addr_b           (rd_addr_b),
      .rd_term_a           (rd_term_a),
      .rd_term_b           (rd_term_b),
      .rsp_valid           (rsp_valid),
      .rsp_result_coeff    (rsp_result_coeff),
      .rsp_result_exponent (rsp_result_exponent),
      .rsp_term_valid      (rsp_term_valid),
      .rsp_last_term       (rsp_last_term),
      .rsp_overflow_seen   (rsp_overflow_seen)
   );

endmodule : sparse_polynomial_add_multiply

`default_nettype wire

// ===== hw/rtl/spam_checker.sv =====
// Port-level checks for the sparse polynomial block, bound to the top level.
`default_nettype none

module spam_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               start,
   input wire logic               busy,
   input wire logic [2:0]         req_kind,
   input wire logic               rsp_valid,
   input wire logic               rsp_term_valid,
   input wire logic               rsp_last_term
);

   // a result only follows a busy cycle
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a run in progress");

   // a run streams without gaps until its last item
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_term) |=> rsp_valid)
      else $error("result stream broke before last item");

   // the last item frees the block
   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_term) |-> !busy)
      else $error("still busy on last item");

   // an empty answer is always a single last item
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_term_valid) |-> rsp_last_term)
      else $error("empty answer not marked last");

   // clear and append never occupy the block
   a_list_ops_quick: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_kind == spam_pkg::KIND_CLEAR ||
                          req_kind == spam_pkg::KIND_APPEND_A ||
                          req_kind == spam_pkg::KIND_APPEND_B)) |=> !busy)
      else $error("list item left the block busy");

endmodule : spam_checker

bind sparse_polynomial_add_multiply spam_checker u_spam_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_kind       (req_kind),
   .rsp_valid      (rsp_valid),
   .rsp_term_valid (rsp_term_valid),
   .rsp_last_term  (rsp_last_term)
);

`default_nettype wire

// ===== tb/sparse_polynomial_add_multiply_test.sv =====
// Self-checking testbench for the sparse polynomial add/multiply block.
`timescale 1ns / 100ps

module sparse_polynomial_add_multiply_test;

   localparam int MAX_TERMS = spam_pkg::MAX_TERMS_DEF;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 16;

   // kinds the block ignores
   localparam logic [2:0] KIND_RESERVED_LO = 3'd5;
   localparam logic [2:0] KIND_RESERVED_HI = 3'd7;

   // one expected output term
   typedef struct {
      logic signed [31:0] coeff;
      logic [8:0]         exponent;
      logic               term_valid;
      logic               last_term;
      logic               overflow_seen;
   } out_term_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [2:0]         req_kind;
   logic signed [15:0] req_term_coeff;
   logic [7:0]         req_term_exponent;
   logic               rsp_valid;
   logic signed [31:0] rsp_result_coeff;
   logic [8:0]         rsp_result_exponent;
   logic               rsp_term_valid;
   logic               rsp_last_term;
   logic               rsp_overflow_seen;

   // predictor state: the two stored polynomials
   spam_pkg::term_type poly_a [MAX_TERMS];
   spam_pkg::term_type poly_b [MAX_TERMS];
   int                 terms_in_a;
   int                 terms_in_b;
   logic               dropped_append;
   out_term_type       pending_terms [$];

   int failures = 0;
   int cycle_count = 0;
   int gap_pct;

   sparse_polynomial_add_multiply DUT (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_kind            (req_kind),
      .req_term_coeff      (req_term_coeff),
      .req_term_exponent   (req_term_exponent),
      .rsp_valid           (rsp_valid),
      .rsp_result_coeff    (rsp_result_coeff),
      .rsp_result_exponent (rsp_result_exponent),
      .rsp_term_valid      (rsp_term_valid),
      .rsp_last_term       (rsp_last_term),
      .rsp_overflow_seen   (rsp_overflow_seen)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // push one output term onto the expected queue
   task automatic queue_term(input logic signed [31:0] coeff, input logic [8:0] exponent,
                             input logic valid, input logic last);
      out_term_type t;
      t.coeff = coeff;
      t.exponent = exponent;
      t.term_valid = valid;
      t.last_term = last;
      t.overflow_seen = dropped_append;
      pending_terms.push_back(t);
   endtask

   // update the polynomial state for one item and queue the terms it emits
   task automatic apply_poly_item(input logic [2:0] kind, input logic signed [15:0] coeff,
                                  input logic [7:0] exponent);
      int i;
      int j;
      int emitted;
      bit take_a;
      bit take_b;
      logic signed [15:0] ca;
      logic signed [15:0] cb;
      logic signed [31:0] rc;
      logic [8:0] re;
      emitted = 0;
      case (kind)
         spam_pkg::KIND_CLEAR: begin
            terms_in_a = 0;
            terms_in_b = 0;
            dropped_append = 1'b0;
         end
         spam_pkg::KIND_APPEND_A: begin
            if (terms_in_a < MAX_TERMS) begin
               poly_a[terms_in_a] = '{coeff: coeff, exponent: exponent};
               terms_in_a++;
            end else begin
               dropped_append = 1'b1;
            end
         end
         spam_pkg::KIND_APPEND_B: begin
            if (terms_in_b < MAX_TERMS) begin
               poly_b[terms_in_b] = '{coeff: coeff, exponent: exponent};
               terms_in_b++;
            end else begin
               dropped_append = 1'b1;
            end
         end
         spam_pkg::KIND_SUM: begin
            // merge from the heads, larger exponent first, equal ones combine
            i = 0;
            j = 0;
            while (i < terms_in_a || j < terms_in_b) begin
               take_a = 1'b0;
               take_b = 1'b0;
               if (i >= terms_in_a) take_b = 1'b1;
               else if (j >= terms_in_b) take_a = 1'b1;
               else if (poly_a[i].exponent == poly_b[j].exponent) begin
                  take_a = 1'b1;
                  take_b = 1'b1;
               end
               else if (poly_a[i].exponent > poly_b[j].exponent) take_a = 1'b1;
               else take_b = 1'b1;
               ca = take_a ? poly_a[i].coeff : 16'sd0;
               cb = take_b ? poly_b[j].coeff : 16'sd0;
               rc = 32'(ca) + 32'(cb);
               re = take_a ? 9'(poly_a[i].exponent) : 9'(poly_b[j].exponent);
               if (take_a) i++;
               if (take_b) j++;
               queue_term(rc, re, 1'b1, i >= terms_in_a && j >= terms_in_b);
               emitted++;
            end
         end
         spam_pkg::KIND_PRODUCT: begin
            // every pair, A outer, B inner, no combining
            for (i = 0; i < terms_in_a; i++) begin
               for (j = 0; j < terms_in_b; j++) begin
                  ca = poly_a[i].coeff;
                  cb = poly_b[j].coeff;
                  rc = 32'(ca) * 32'(cb);
                  re = 9'(poly_a[i].exponent) + 9'(poly_b[j].exponent);
                  queue_term(rc, re, 1'b1, i + 1 == terms_in_a && j + 1 == terms_in_b);
                  emitted++;
               end
            end
         end
         default: ;
      endcase
      // empty answer: one invalid term marked last
      if ((kind == spam_pkg::KIND_SUM || kind == spam_pkg::KIND_PRODUCT) && emitted == 0)
         queue_term(32'sd0, 9'd0, 1'b0, 1'b1);
   endtask

   // drive one item, wait for it to be taken, then predict its results
   task automatic send_item(input logic [2:0] kind, input logic signed [15:0] coeff,
                            input logic [7:0] exponent);
      while ($urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_kind <= kind;
      req_term_coeff <= coeff;
      req_term_exponent <= exponent;
      do @(posedge clock); while (busy);
      apply_poly_item(kind, coeff, exponent);
   endtask

   task automatic check_field(input string field, input logic signed [31:0] expected,
                              input logic signed [31:0] actual);
      if (expected !== actual) begin
         $error("%s mismatch: expected %0d, got %0d", field, expected, actual);
         failures++;
      end
   endtask

   // compare each emitted term with the oldest expectation
   always @(posedge clock) begin
      out_term_type t;
      if (!reset && rsp_valid) begin
         if (pending_terms.size() == 0) begin
            $error("unexpected result term: coeff %0d exponent %0d",
                   rsp_result_coeff, rsp_result_exponent);
            failures++;
         end else begin
            t = pending_terms.pop_front();
            check_field("result_coeff", t.coeff, rsp_result_coeff);
            check_field("result_exponent", t.exponent, rsp_result_exponent);
            check_field("term_valid", t.term_valid, rsp_term_valid);
            check_field("last_term", t.last_term, rsp_last_term);
            check_field("overflow_seen", t.overflow_seen, rsp_overflow_seen);
         end
      end
   end

   // empty answers: both lists empty, then one side empty
   task automatic test_empty_answers();
      send_item(spam_pkg::KIND_SUM, 16'sd0, 8'd0);
      send_item(spam_pkg::KIND_PRODUCT, 16'sd0, 8'd0);
      send_item(spam_pkg::KIND_APPEND_B, 16'sd5, 8'd3);
      send_item(spam_pkg::KIND_PRODUCT, 16'sd0, 8'd0);
      send_item(spam_pkg::KIND_SUM, 16'sd0, 8'd0);
   endtask

   // coefficient and exponent extremes, matching exponents in the sum
   task automatic test_extremes();
      send_item(spam_pkg::KIND_CLEAR, 16'sd0, 8'd0);
      send_item(spam_pkg::KIND_APPEND_A, 16'sh7fff, 8'd255);
      send_item(spam_pkg::KIND_APPEND_A, -16'sh8000, 8'd0);
      send_item(spam_pkg::KIND_APPEND_B, -16'sh8000, 8'd255);
      send_item(spam_pkg::KIND_APPEND_B, -16'sh8000, 8'd0);
      send_item(spam_pkg::KIND_SUM, 16'sd0, 8'd0);
      send_item(spam_pkg::KIND_PRODUCT, 16'sd0, 8'd0);
   endtask

   // reserved kinds must leave the lists alone
   task automatic test_unused_kinds();
      logic [2:0] k;
      for (k = KIND_RESERVED_LO; k <= KIND_RESERVED_HI && k >= KIND_RESERVED_LO; k++)
         send_item(k, 16'($urandom), 8'($urandom));
   endtask

   // fill A past capacity, see the sticky flag, then clear it
   task automatic test_overflow();
      int n;
      for (n = 0; n <= MAX_TERMS; n++)
         send_item(spam_pkg::KIND_APPEND_A, 16'($urandom), 8'(MAX_TERMS - n));
      send_item(spam_pkg::KIND_SUM, 16'sd0, 8'd0);
      send_item(spam_pkg::KIND_CLEAR, 16'sd0, 8'd0);
      send_item(spam_pkg::KIND_SUM, 16'sd0, 8'd0);
   endtask

   // random coefficient, extremes now and then
   function automatic logic signed [15:0] pick_coeff();
      if ($urandom_range(7) == 0) return $urandom_range(1) ? 16'sh7fff : -16'sh8000;
      return 16'($urandom);
   endfunction

   // mostly well-formed load-then-compute sequences, some stray items
   task automatic test_random_sequences(input int idle_pct, input int budget);
      int sent;
      int left_a;
      int left_b;
      int step;
      bit sorted;
      bit narrow;
      bit to_a;
      logic [7:0] ceil_a;
      logic [7:0] ceil_b;
      logic [7:0] e;
      logic [2:0] k;
      int op;
      gap_pct = idle_pct;
      sent = 0;
      while (sent < budget) begin
         if ($urandom_range(9) == 0) begin
            k = 3'($urandom_range(KIND_RESERVED_HI));
            send_item(k, 16'($urandom), 8'($urandom));
            if (k <= spam_pkg::KIND_PRODUCT) sent++;
         end else begin
            send_item(spam_pkg::KIND_CLEAR, 16'($urandom), 8'($urandom));
            left_a = $urandom_range(MAX_TERMS + 2);
            left_b = $urandom_range(MAX_TERMS + 2);
            sorted = $urandom_range(3) != 0;
            narrow = $urandom_range(1) != 0;
            ceil_a = narrow ? 8'd7 : 8'($urandom_range(255));
            ceil_b = narrow ? 8'd7 : 8'($urandom_range(255));
            sent += 1 + left_a + left_b;
            while (left_a + left_b > 0) begin
               to_a = left_b == 0 || (left_a > 0 && $urandom_range(1));
               step = $urandom_range(3);
               if (to_a) begin
                  if (sorted) e = ceil_a > step ? ceil_a - 8'(step) : 8'd0;
                  else e = narrow ? 8'($urandom_range(7)) : 8'($urandom);
                  if (sorted) ceil_a = e;
                  send_item(spam_pkg::KIND_APPEND_A, pick_coeff(), e);
                  left_a--;
               end else begin
                  if (sorted) e = ceil_b > step ? ceil_b - 8'(step) : 8'd0;
                  else e = narrow ? 8'($urandom_range(7)) : 8'($urandom);
                  if (sorted) ceil_b = e;
                  send_item(spam_pkg::KIND_APPEND_B, pick_coeff(), e);
                  left_b--;
               end
            end
            op = $urandom_range(2);
            if (op != 1) begin
               send_item(spam_pkg::KIND_SUM, 16'($urandom), 8'($urandom));
               sent++;
            end
            if (op != 0) begin
               send_item(spam_pkg::KIND_PRODUCT, 16'($urandom), 8'($urandom));
               sent++;
            end
         end
      end
   endtask

   // reset, directed tests, random phases, drain and verdict
   initial begin
      gap_pct = 0;
      terms_in_a = 0;
      terms_in_b = 0;
      dropped_append = 1'b0;
      reset <= 1'b1;
      start <= 1'b0;
      req_kind <= spam_pkg::KIND_CLEAR;
      req_term_coeff <= 16'sd0;
      req_term_exponent <= 8'd0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_empty_answers();
      test_extremes();
      test_unused_kinds();
      test_overflow();
      test_random_sequences(0, 25);
      test_random_sequences(82, 20);
      test_random_sequences(15, 20);

      start <= 1'b0;
      while (pending_terms.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule

// ===== sparse_polynomial_add_multiply.f =====
hw/rtl/spam_pkg.sv
hw/rtl/spam_term_mem.sv
hw/rtl/spam_engine.sv
hw/rtl/sparse_polynomial_add_multiply.sv
hw/rtl/spam_checker.sv
tb/sparse_polynomial_add_multiply_test.sv
